// ===== rtl/rolling_zscore_pair_signal_defines.svh =====
// ---------------------------------------------------------------------------
// rolling_zscore_pair_signal_defines.svh
// Assertion macros shared by the rolling z-score pair signal rtl
// ---------------------------------------------------------------------------
`ifndef ROLLING_ZSCORE_PAIR_SIGNAL_DEFINES_SVH
`define ROLLING_ZSCORE_PAIR_SIGNAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RZSP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RZSP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rzsp_pkg.sv =====
// ---------------------------------------------------------------------------
// rzsp_pkg
// Shared constants, control word layout and microprogram for the pair signal
// ---------------------------------------------------------------------------
package rzsp_pkg;

    // field widths
    localparam int PRICE_W    = 24;
    localparam int THR_W      = 24;
    localparam int SPREAD_W   = 25;
    localparam int SIG_W      = 3;
    localparam int DEF_WINDOW = 8;

    // shared multiplier and accumulator
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 128;

    // result codes
    localparam logic [SIG_W-1:0] SIG_WARM  = 3'd0;
    localparam logic [SIG_W-1:0] SIG_SHORT = 3'd1;
    localparam logic [SIG_W-1:0] SIG_LONG  = 3'd2;
    localparam logic [SIG_W-1:0] SIG_CLOSE = 3'd3;
    localparam logic [SIG_W-1:0] SIG_HOLD  = 3'd4;

    // configuration registers
    localparam int               CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT  = 1'b1;
    localparam logic [THR_W-1:0] ENTRY_RESET = 24'd65536;
    localparam logic [THR_W-1:0] EXIT_RESET  = 24'd52429;

    // microprogram addressing
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
    localparam logic [STEP_W-1:0] STEP_PUSH = 5'd17;
    localparam logic [STEP_W-1:0] STEP_EMIT = 5'd18;
    localparam logic [STEP_W-1:0] STEP_WARM = 5'd19;

    // multiplier operand pairs
    typedef enum logic [3:0] {
        MUL_XSQ   = 4'd0,
        MUL_OLDSQ = 4'd1,
        MUL_SUMSQ = 4'd2,
        MUL_DSQ   = 4'd3,
        MUL_TESQ  = 4'd4,
        MUL_TXSQ  = 4'd5,
        MUL_TV00  = 4'd6,
        MUL_TV01  = 4'd7,
        MUL_TV10  = 4'd8,
        MUL_TV11  = 4'd9
    } mul_sel_t;

    // accumulator operations
    typedef enum logic [2:0] {
        ACC_HOLD   = 3'd0,
        ACC_WQ_SUB = 3'd1,
        ACC_LOAD   = 3'd2,
        ACC_ADD32  = 3'd3,
        ACC_ADD64  = 3'd4
    } acc_op_t;

    // sequencer branch kinds
    typedef enum logic [2:0] {
        JMP_NEXT     = 3'd0,
        JMP_ALWAYS   = 3'd1,
        JMP_WARM     = 3'd2,
        JMP_WAIT_IN  = 3'd3,
        JMP_WAIT_OUT = 3'd4
    } jump_t;

    // one control word
    typedef struct packed {
        mul_sel_t           mul_sel;
        acc_op_t            acc_op;
        logic               wr_d;
        logic               wr_var;
        logic               wr_dsq;
        logic               wr_tsq;
        logic               cmp_ent;
        logic               cmp_ext;
        logic               sub_old;
        logic               add_x;
        logic               emit;
        jump_t              jump;
        logic [STEP_W-1:0]  target;
    } uword_t;

    // status fed back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic warm;
        logic out_free;
    } seq_stat_t;

    // control store: each product is registered and comes out in the step after its operands
    function automatic uword_t ucode(input logic [STEP_W-1:0] s);
        uword_t w;
        w = '0;
        case (s)
            5'd0:
            begin
                w.jump = JMP_WAIT_IN;
            end
            5'd1:
            begin
                w.mul_sel = MUL_SUMSQ;
                w.wr_d    = 1'b1;
                w.jump    = JMP_WARM;
                w.target  = STEP_WARM;
            end
            5'd2:
            begin
                w.mul_sel = MUL_DSQ;
                w.acc_op  = ACC_WQ_SUB;
            end
            5'd3:
            begin
                w.mul_sel = MUL_TESQ;
                w.wr_var  = 1'b1;
                w.wr_dsq  = 1'b1;
            end
            5'd4:
            begin
                w.wr_tsq = 1'b1;
            end
            5'd5:
            begin
                w.mul_sel = MUL_TV00;
            end
            5'd6:
            begin
                w.mul_sel = MUL_TV01;
                w.acc_op  = ACC_LOAD;
            end
            5'd7:
            begin
                w.mul_sel = MUL_TV10;
                w.acc_op  = ACC_ADD32;
            end
            5'd8:
            begin
                w.mul_sel = MUL_TV11;
                w.acc_op  = ACC_ADD32;
            end
            5'd9:
            begin
                w.mul_sel = MUL_TXSQ;
                w.acc_op  = ACC_ADD64;
            end
            5'd10:
            begin
                w.cmp_ent = 1'b1;
                w.wr_tsq  = 1'b1;
            end
            5'd11:
            begin
                w.mul_sel = MUL_TV00;
            end
            5'd12:
            begin
                w.mul_sel = MUL_TV01;
                w.acc_op  = ACC_LOAD;
            end
            5'd13:
            begin
                w.mul_sel = MUL_TV10;
                w.acc_op  = ACC_ADD32;
            end
            5'd14:
            begin
                w.mul_sel = MUL_TV11;
                w.acc_op  = ACC_ADD32;
            end
            5'd15:
            begin
                w.mul_sel = MUL_OLDSQ;
                w.acc_op  = ACC_ADD64;
            end
            5'd16:
            begin
                w.mul_sel = MUL_XSQ;
                w.cmp_ext = 1'b1;
                w.sub_old = 1'b1;
            end
            5'd17:
            begin
                w.add_x = 1'b1;
            end
            5'd18:
            begin
                w.emit   = 1'b1;
                w.jump   = JMP_WAIT_OUT;
                w.target = STEP_IDLE;
            end
            5'd19:
            begin
                w.mul_sel = MUL_XSQ;
                w.jump    = JMP_ALWAYS;
                w.target  = STEP_PUSH;
            end
            default:
            begin
                w.jump   = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/rzsp_ram.sv =====
// ---------------------------------------------------------------------------
// rzsp_ram
// Generic single-write, single-read RAM with registered read data
// ---------------------------------------------------------------------------
module rzsp_ram #(
    parameter int  WIDTH  = rzsp_pkg::SPREAD_W,
    parameter int  DEPTH  = rzsp_pkg::DEF_WINDOW,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rzsp_seq.sv =====
// ---------------------------------------------------------------------------
// rzsp_seq
// Step counter and control store with conditional branches
// ---------------------------------------------------------------------------
module rzsp_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  rzsp_pkg::seq_stat_t stat,
    output rzsp_pkg::uword_t   ctrl,
    output logic               idle
);

    logic [rzsp_pkg::STEP_W-1:0] step_reg;
    logic [rzsp_pkg::STEP_W-1:0] step_next;
    logic [rzsp_pkg::STEP_W-1:0] step_inc;

    // control word for the current step
    assign ctrl     = rzsp_pkg::ucode(step_reg);
    assign idle     = (step_reg == rzsp_pkg::STEP_IDLE);
    assign step_inc = step_reg + rzsp_pkg::STEP_W'(1);

    // branch resolution
    always_comb
    begin
        case (ctrl.jump)
            rzsp_pkg::JMP_NEXT:     step_next = step_inc;
            rzsp_pkg::JMP_ALWAYS:   step_next = ctrl.target;
            rzsp_pkg::JMP_WARM:     step_next = stat.warm ? ctrl.target : step_inc;
            rzsp_pkg::JMP_WAIT_IN:  step_next = stat.in_fire ? step_inc : step_reg;
            rzsp_pkg::JMP_WAIT_OUT: step_next = stat.out_free ? ctrl.target : step_reg;
            default:                step_next = rzsp_pkg::STEP_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= rzsp_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/rzsp_dp.sv =====
// ---------------------------------------------------------------------------
// rzsp_dp
// Window state, shared multiplier, wide accumulator and signal decision
// ---------------------------------------------------------------------------
`include "rolling_zscore_pair_signal_defines.svh"

module rzsp_dp #(
    parameter int  WINDOW = rzsp_pkg::DEF_WINDOW,
    localparam int WIN_LOG = $clog2(WINDOW),
    localparam int SLOT_W  = $clog2(WINDOW),
    localparam int FILL_W  = $clog2(WINDOW + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rzsp_pkg::uword_t              ctrl,
    input  logic                          in_fire,
    input  logic [rzsp_pkg::PRICE_W-1:0]  price_first,
    input  logic [rzsp_pkg::PRICE_W-1:0]  price_second,
    input  logic [rzsp_pkg::THR_W-1:0]    entry_thr,
    input  logic [rzsp_pkg::THR_W-1:0]    exit_thr,
    output logic                          warm,
    output logic [rzsp_pkg::SIG_W-1:0]    result
);

    localparam int SPREAD_W = rzsp_pkg::SPREAD_W;
    localparam int MUL_W    = rzsp_pkg::MUL_W;
    localparam int PROD_W   = rzsp_pkg::PROD_W;
    localparam int ACC_W    = rzsp_pkg::ACC_W;
    localparam int SUM_W    = SPREAD_W + WIN_LOG;
    localparam int SQ_W     = 2 * rzsp_pkg::PRICE_W + WIN_LOG;
    localparam int D_W      = SPREAD_W + WIN_LOG + 1;
    localparam logic signed [D_W-1:0] WIN_D   = D_W'(WINDOW);
    localparam logic [ACC_W-1:0]      WIN_ACC = ACC_W'(WINDOW);

    // window state
    logic [SLOT_W-1:0]        slot_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]          sq_reg;

    // working registers
    logic signed [SPREAD_W-1:0] x_reg;
    logic signed [D_W-1:0]      d_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;
    logic [PROD_W-1:0]          var_reg;
    logic [PROD_W-1:0]          dsq_reg;
    logic [PROD_W-1:0]          tsq_reg;
    logic                       gt_reg;
    logic                       lt_reg;
    logic                       warm_reg;

    logic [SPREAD_W-1:0]        old_raw;
    logic signed [SPREAD_W-1:0] old_spread;
    logic signed [SPREAD_W-1:0] x_next;
    logic signed [D_W-1:0]      d_calc;
    logic [MUL_W-1:0]           x_mag;
    logic [MUL_W-1:0]           old_mag;
    logic [MUL_W-1:0]           sum_mag;
    logic [MUL_W-1:0]           d_mag;
    logic [MUL_W-1:0]           op_a;
    logic [MUL_W-1:0]           op_b;
    logic [ACC_W-1:0]           lhs;
    logic                       d_pos;
    logic                       d_neg;

    // spread ring
    rzsp_ram #(
        .WIDTH (SPREAD_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ctrl.add_x),
        .waddr (slot_reg),
        .wdata (x_reg),
        .re    (in_fire),
        .raddr (slot_reg),
        .rdata (old_raw)
    );

    assign old_spread = $signed(old_raw);
    assign x_next     = $signed({1'b0, price_first}) - $signed({1'b0, price_second});
    assign d_calc     = D_W'(x_reg) * WIN_D - D_W'(sum_reg);
    assign warm       = (fill_reg < FILL_W'(WINDOW));

    // magnitudes for squaring
    always_comb
    begin
        x_mag   = x_reg[SPREAD_W-1] ? MUL_W'(-x_reg) : MUL_W'(x_reg);
        old_mag = old_spread[SPREAD_W-1] ? MUL_W'(-old_spread) : MUL_W'(old_spread);
        sum_mag = sum_reg[SUM_W-1] ? MUL_W'(-sum_reg) : MUL_W'(sum_reg);
        d_mag   = d_reg[D_W-1] ? MUL_W'(-d_reg) : MUL_W'(d_reg);
    end

    // multiplier operand select
    always_comb
    begin
        case (ctrl.mul_sel)
            rzsp_pkg::MUL_XSQ:
            begin
                op_a = x_mag;
                op_b = x_mag;
            end
            rzsp_pkg::MUL_OLDSQ:
            begin
                op_a = old_mag;
                op_b = old_mag;
            end
            rzsp_pkg::MUL_SUMSQ:
            begin
                op_a = sum_mag;
                op_b = sum_mag;
            end
            rzsp_pkg::MUL_DSQ:
            begin
                op_a = d_mag;
                op_b = d_mag;
            end
            rzsp_pkg::MUL_TESQ:
            begin
                op_a = MUL_W'(entry_thr);
                op_b = MUL_W'(entry_thr);
            end
            rzsp_pkg::MUL_TXSQ:
            begin
                op_a = MUL_W'(exit_thr);
                op_b = MUL_W'(exit_thr);
            end
            rzsp_pkg::MUL_TV00:
            begin
                op_a = tsq_reg[MUL_W-1:0];
                op_b = var_reg[MUL_W-1:0];
            end
            rzsp_pkg::MUL_TV01:
            begin
                op_a = tsq_reg[MUL_W-1:0];
                op_b = var_reg[PROD_W-1:MUL_W];
            end
            rzsp_pkg::MUL_TV10:
            begin
                op_a = tsq_reg[PROD_W-1:MUL_W];
                op_b = var_reg[MUL_W-1:0];
            end
            rzsp_pkg::MUL_TV11:
            begin
                op_a = tsq_reg[PROD_W-1:MUL_W];
                op_b = var_reg[PROD_W-1:MUL_W];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // accumulator: variance term and threshold-times-variance partial products
    always_comb
    begin
        case (ctrl.acc_op)
            rzsp_pkg::ACC_HOLD:   acc_next = acc_reg;
            rzsp_pkg::ACC_WQ_SUB: acc_next = ACC_W'(sq_reg) * WIN_ACC - ACC_W'(prod_reg);
            rzsp_pkg::ACC_LOAD:   acc_next = ACC_W'(prod_reg);
            rzsp_pkg::ACC_ADD32:  acc_next = acc_reg + (ACC_W'(prod_reg) << MUL_W);
            rzsp_pkg::ACC_ADD64:  acc_next = acc_reg + (ACC_W'(prod_reg) << PROD_W);
            default:              acc_next = acc_reg;
        endcase
    end

    // scaled squared deviation, compared against t*t*V
    assign lhs = ACC_W'(dsq_reg) << MUL_W;

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        acc_reg  <= acc_next;
        if (in_fire)
        begin
            x_reg <= x_next;
        end
        if (ctrl.wr_d)
        begin
            d_reg    <= d_calc;
            warm_reg <= warm;
        end
        if (ctrl.wr_var)
        begin
            var_reg <= acc_reg[PROD_W-1:0];
        end
        if (ctrl.wr_dsq)
        begin
            dsq_reg <= prod_reg;
        end
        if (ctrl.wr_tsq)
        begin
            tsq_reg <= prod_reg;
        end
        if (ctrl.cmp_ent)
        begin
            gt_reg <= (lhs > acc_reg);
        end
        if (ctrl.cmp_ext)
        begin
            lt_reg <= (lhs < acc_reg);
        end
    end

    // window update: add the new spread, first dropping the oldest once the window is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
        end
        else if (ctrl.sub_old)
        begin
            sum_reg <= sum_reg - SUM_W'(old_spread);
            sq_reg  <= sq_reg - prod_reg[SQ_W-1:0];
        end
        else if (ctrl.add_x)
        begin
            sum_reg  <= sum_reg + SUM_W'(x_reg);
            sq_reg   <= sq_reg + prod_reg[SQ_W-1:0];
            slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
            if (warm)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // signal decision, short and long ahead of close
    assign d_pos = !d_reg[D_W-1] && (d_reg != '0);
    assign d_neg = d_reg[D_W-1];

    always_comb
    begin
        if (warm_reg)
        begin
            result = rzsp_pkg::SIG_WARM;
        end
        else if (gt_reg && d_pos)
        begin
            result = rzsp_pkg::SIG_SHORT;
        end
        else if (gt_reg && d_neg)
        begin
            result = rzsp_pkg::SIG_LONG;
        end
        else if (lt_reg)
        begin
            result = rzsp_pkg::SIG_CLOSE;
        end
        else
        begin
            result = rzsp_pkg::SIG_HOLD;
        end
    end

    // window bookkeeping stays in range
    `RZSP_ASSERT_IMP(a_fill_range, 1'b1, fill_reg <= FILL_W'(WINDOW), "fill count above window")
    `RZSP_ASSERT_NEXT(a_fill_step, ctrl.add_x && warm, fill_reg == $past(fill_reg) + FILL_W'(1),
        "fill count did not advance during warm-up")

endmodule

// ===== rtl/rolling_zscore_pair_signal.sv =====
// ---------------------------------------------------------------------------
// rolling_zscore_pair_signal
// Pair-trading signal from the z-score of a price spread over a rolling window
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per tick: the two
//   prices in hundredths. Output channel (out_valid / out_stall) returns one
//   signal code per request: warming up, short, long, close or hold.
//   One request is in work at a time; in_stall is high from acceptance until
//   the result has moved into the output register.
//   During warm-up (the first WINDOW requests) a request takes a shorter path
//   through the microprogram; for a full-window request it walks 14 products
//   through one shared 32x32 multiplier and a 128-bit accumulator. The result
//   waits in the output register while out_stall is high; the next request
//   is still accepted and worked on, and only its final step waits for the
//   output register to free up. Thresholds must be written by the user
//   through cfg_write / cfg_index / cfg_data only while no request is in
//   work; the block itself does not enforce this. Reset clears the window
//   (sum, sum of squares, fill count, ring pointer) and restores the
//   thresholds to 1.0 and about 0.8.
// ---------------------------------------------------------------------------
`include "rolling_zscore_pair_signal_defines.svh"

module rolling_zscore_pair_signal #(
    parameter int WINDOW = rzsp_pkg::DEF_WINDOW
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [rzsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rzsp_pkg::THR_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rzsp_pkg::PRICE_W-1:0]    price_first,
    input  logic [rzsp_pkg::PRICE_W-1:0]    price_second,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rzsp_pkg::SIG_W-1:0]      signal
);

    logic [rzsp_pkg::THR_W-1:0] entry_thr_reg;
    logic [rzsp_pkg::THR_W-1:0] exit_thr_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [rzsp_pkg::SIG_W-1:0] signal_reg;
    logic [rzsp_pkg::SIG_W-1:0] result;
    logic                       in_fire;
    logic                       out_free;
    logic                       emit_fire;
    logic                       idle;
    logic                       warm;
    rzsp_pkg::uword_t           ctrl;
    rzsp_pkg::seq_stat_t        stat;

    // handshakes
    assign in_stall  = !idle;
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = ctrl.emit && out_free;

    assign stat.in_fire  = in_fire;
    assign stat.warm     = warm;
    assign stat.out_free = out_free;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_thr_reg <= rzsp_pkg::ENTRY_RESET;
            exit_thr_reg  <= rzsp_pkg::EXIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rzsp_pkg::CFG_ENTRY: entry_thr_reg <= cfg_data;
                rzsp_pkg::CFG_EXIT:  exit_thr_reg  <= cfg_data;
                default:             entry_thr_reg <= entry_thr_reg;
            endcase
        end
    end

    // sequencer
    rzsp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .idle  (idle)
    );

    // datapath
    rzsp_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .in_fire      (in_fire),
        .price_first  (price_first),
        .price_second (price_second),
        .entry_thr    (entry_thr_reg),
        .exit_thr     (exit_thr_reg),
        .warm         (warm),
        .result       (result)
    );

    // output register
    assign out_valid_next = emit_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            signal_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign signal    = signal_reg;

    // one request in work at a time, and only defined codes leave
    `RZSP_ASSERT_NEXT(a_single_request, in_fire, in_stall, "request accepted while busy")
    `RZSP_ASSERT_IMP(a_code_range, out_valid, signal <= rzsp_pkg::SIG_HOLD,
        "undefined signal code")

endmodule
